// ===== rtl/cbls_pkg.sv =====
// Shared types and constants for the context bit lane splitter.
// No dependencies; the other RTL files that use it refer to this package by scoped names.
package cbls_pkg;

  localparam int unsigned LANE_COUNT_DEF = 256;

  // request word kinds
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    MODE_FLAT     = 4'd0,
    MODE_BITPOS8  = 4'd1,
    MODE_BITPOS32 = 4'd2,
    MODE_PREV1    = 4'd3,
    MODE_PREV3    = 4'd4,
    MODE_PREV6    = 4'd5,
    MODE_PREV8    = 4'd6,
    MODE_PREVBYTE = 4'd7,
    MODE_PREVPOP  = 4'd8
  } cbls_mode_e;

  // One lane's stored state: bits held and the left-aligned partial byte.
  typedef struct packed {
    logic [2:0] fill;
    logic [7:0] acc;
  } lane_entry_t;

  // History seen by the lane context unit for one bit.
  typedef struct packed {
    logic [7:0] prev_byte;
    logic [7:0] cur_byte;
    logic [1:0] phase;
    logic [2:0] bit_idx;
  } ctx_t;

  typedef struct packed {
    logic [7:0] lane_number;
    logic [7:0] lane_byte;
    logic [3:0] bit_count;
    logic       last_of_run;
  } result_t;

endpackage

// ===== rtl/cbls_req_if.sv =====
// Input channel of the splitter: valid/ready plus one request word.
// Depends on nothing.
interface cbls_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic [7:0] flush_lane;

  modport source (output valid, output req_type, output data_byte, output flush_lane,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input flush_lane,
                  output ready);
endinterface

// ===== rtl/cbls_res_if.sv =====
// Output channel of the splitter: valid/ready plus one result word.
// Depends on nothing.
interface cbls_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] lane_number;
  logic [7:0] lane_byte;
  logic [3:0] bit_count;
  logic       last_of_run;

  modport source (output valid, output lane_number, output lane_byte, output bit_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input lane_number, input lane_byte, input bit_count,
                  input last_of_run, output ready);
endinterface

// ===== rtl/cbls_lane_ctx.sv =====
// Lane context unit: maps the current bit position and history to a lane number.
// Depends on cbls_pkg.
module cbls_lane_ctx (
  input  logic [3:0]    mode_i,
  input  cbls_pkg::ctx_t ctx_i,
  output logic [7:0]    lane_o
);

  logic [15:0] window;
  logic [15:0] hist;
  logic [3:0]  pop;

  always_comb begin
    window = {ctx_i.prev_byte, ctx_i.cur_byte};
    // bits just before the current one; at bit 0 this is the previous byte
    hist   = window >> (4'd8 - {1'b0, ctx_i.bit_idx});
    pop    = '0;
    for (int k = 0; k < 8; k++) begin
      pop = pop + {3'b000, ctx_i.prev_byte[k]};
    end
  end

  always_comb begin
    unique case (mode_i)
      cbls_pkg::MODE_BITPOS8:  lane_o = {5'b00000, ctx_i.bit_idx};
      cbls_pkg::MODE_BITPOS32: lane_o = {3'b000, ctx_i.phase, ctx_i.bit_idx};
      cbls_pkg::MODE_PREV1:    lane_o = {7'b0000000, hist[0]};
      cbls_pkg::MODE_PREV3:    lane_o = {5'b00000, hist[2:0]};
      cbls_pkg::MODE_PREV6:    lane_o = {2'b00, hist[5:0]};
      cbls_pkg::MODE_PREV8:    lane_o = hist[7:0];
      cbls_pkg::MODE_PREVBYTE: lane_o = ctx_i.prev_byte;
      cbls_pkg::MODE_PREVPOP:  lane_o = {4'b0000, pop};
      default:                 lane_o = '0;  // flat and unused codes
    endcase
  end

endmodule

// ===== rtl/cbls_lane_mem.sv =====
// Lane state memory: one write port, one registered read port.
// Per-entry valid flops make every lane read as empty after reset. Depends on cbls_pkg.
module cbls_lane_mem #(
  parameter int unsigned LANE_COUNT = cbls_pkg::LANE_COUNT_DEF,
  localparam int unsigned AW = $clog2(LANE_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output cbls_pkg::lane_entry_t rd_entry_o,
  input  logic                  we_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  cbls_pkg::lane_entry_t wr_entry_i
);

  cbls_pkg::lane_entry_t mem [LANE_COUNT];
  cbls_pkg::lane_entry_t rd_data_q;
  logic [LANE_COUNT-1:0] vld_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/context_bit_lane_splitter.sv =====
// Context bit lane splitter, top level.
// Depends on cbls_pkg, cbls_req_if, cbls_res_if, cbls_lane_ctx and cbls_lane_mem.
//
// Usage:
//   req_i carries one request word: a data byte to split (req_type 0) or a flush
//   of one lane (req_type 1). res_o carries result words: lane number, packed
//   byte, valid bit count and a last flag on the final result of a request.
//   cfg_we_i/cfg_wdata_i write context_mode; write it only while idle.
// Sequence:
//   A data byte passes through an accept state, then a read and a write of the
//   lane memory for each of its 8 bits, then a closing state. Each bit is a
//   read-modify-write of the registered lane memory.
//   A flush goes through accept, read and write; a flush that hits an empty
//   or out-of-range lane gives no result. req_i.ready is high only when idle.
//   Each filled byte is held back one step so that the last flag is known.
// Reset: all lanes read as empty at once (per-lane valid flops), history and
//   mode clear to zero; no clearing pass.
// Stall: results wait in an output register; when it and the held-back
//   result are both full, a bit that completes a byte waits until res_o.ready.
module context_bit_lane_splitter #(
  parameter int unsigned LANE_COUNT = cbls_pkg::LANE_COUNT_DEF,
  localparam int unsigned AW = $clog2(LANE_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  cbls_req_if.sink          req_i,
  cbls_res_if.source        res_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RD    = 6'b000010,
    ST_WR    = 6'b000100,
    ST_END   = 6'b001000,
    ST_FL_RD = 6'b010000,
    ST_FL_WR = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [3:0] mode_q;
  logic [7:0] prev_q, prev_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] cur_q, cur_d;
  logic [7:0] lane_q, lane_d;
  logic       inr_q, inr_d;

  logic              pend_vld_q, pend_vld_d;
  cbls_pkg::result_t pend_q, pend_d;
  logic              out_vld_q, out_vld_d;
  cbls_pkg::result_t out_q, out_d;

  cbls_pkg::ctx_t        ctx;
  logic [7:0]            ctx_lane;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  cbls_pkg::lane_entry_t rd_entry;
  logic                  we;
  cbls_pkg::lane_entry_t wr_entry;

  logic       out_free;
  logic       cur_bit;
  logic       full;
  logic [7:0] acc_new;

  assign ctx = '{prev_byte: prev_q, cur_byte: cur_q, phase: phase_q, bit_idx: idx_q};

  cbls_lane_ctx u_ctx (
    .mode_i (mode_q),
    .ctx_i  (ctx),
    .lane_o (ctx_lane)
  );

  cbls_lane_mem #(
    .LANE_COUNT (LANE_COUNT)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .we_i       (we),
    .wr_addr_i  (lane_q[AW-1:0]),
    .wr_entry_i (wr_entry)
  );

  assign out_free    = !out_vld_q || res_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    cur_bit = cur_q[3'd7 - idx_q];
    full    = (rd_entry.fill == 3'd7);
    acc_new = rd_entry.acc | (cur_bit ? (8'h80 >> rd_entry.fill) : 8'h00);
  end

  always_comb begin
    state_d    = state_q;
    prev_d     = prev_q;
    phase_d    = phase_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    lane_d     = lane_q;
    inr_d      = inr_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    out_d      = out_q;
    rd_en      = 1'b0;
    rd_addr    = lane_q[AW-1:0];
    we         = 1'b0;
    wr_entry   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cur_d  = req_i.data_byte;
          lane_d = req_i.flush_lane;
          idx_d  = '0;
          if (req_i.req_type == cbls_pkg::REQ_DATA) begin
            state_d = ST_RD;
          end else if ({1'b0, req_i.flush_lane} < 9'(LANE_COUNT)) begin
            state_d = ST_FL_RD;
          end
        end
      end

      ST_RD: begin
        lane_d  = ctx_lane;
        inr_d   = ({1'b0, ctx_lane} < 9'(LANE_COUNT));
        rd_en   = 1'b1;
        rd_addr = ctx_lane[AW-1:0];
        state_d = ST_WR;
      end

      ST_WR: begin
        // a new full byte needs the held-back one moved out first
        if (!(inr_q && full && pend_vld_q && !out_free)) begin
          if (inr_q) begin
            we       = 1'b1;
            wr_entry = full ? '0 : cbls_pkg::lane_entry_t'{fill: rd_entry.fill + 3'd1,
                                                           acc: acc_new};
            if (full) begin
              if (pend_vld_q) begin
                out_vld_d = 1'b1;
                out_d     = pend_q;
              end
              pend_vld_d = 1'b1;
              pend_d     = '{lane_number: lane_q, lane_byte: acc_new, bit_count: 4'd8,
                             last_of_run: 1'b0};
            end
          end
          if (idx_q == 3'd7) begin
            prev_d  = cur_q;
            phase_d = phase_q + 2'd1;
            state_d = ST_END;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = ST_RD;
          end
        end
      end

      ST_END: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d         = 1'b1;
          out_d             = pend_q;
          out_d.last_of_run = 1'b1;
          pend_vld_d        = 1'b0;
          state_d           = ST_IDLE;
        end
      end

      ST_FL_RD: begin
        rd_en   = 1'b1;
        state_d = ST_FL_WR;
      end

      ST_FL_WR: begin
        if (rd_entry.fill == 3'd0) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          we        = 1'b1;
          out_vld_d = 1'b1;
          out_d     = '{lane_number: lane_q, lane_byte: rd_entry.acc,
                        bit_count: {1'b0, rd_entry.fill}, last_of_run: 1'b1};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= '0;
      prev_q     <= '0;
      phase_q    <= '0;
      idx_q      <= '0;
      inr_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      prev_q     <= prev_d;
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      inr_q      <= inr_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    lane_q <= lane_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.lane_number = out_q.lane_number;
  assign res_o.lane_byte   = out_q.lane_byte;
  assign res_o.bit_count   = out_q.bit_count;
  assign res_o.last_of_run = out_q.last_of_run;

endmodule
